/* design/multichannel_pid_motor_drive_macros.svh */
// Assertion macros used by the port checker.
`ifndef MULTICHANNEL_PID_MOTOR_DRIVE_MACROS_SVH
`define MULTICHANNEL_PID_MOTOR_DRIVE_MACROS_SVH

// Same-cycle implication, gated off while in reset.
`define MPID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mpid port check failed");

// Next-cycle implication, gated off while in reset.
`define MPID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mpid port check failed");

`endif

/* design/mpid_pkg.sv */
// Types, constants and helpers of the multichannel PID motor drive.
`default_nettype none

package mpid_pkg;

	// Sizing
	localparam int unsigned CHANNELS_DEF = 4;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned SLOT_MAX_W   = 4;

	// Limits
	localparam int ERR_LIMIT   = 499;
	localparam int DRIVE_LIMIT = 499;
	localparam int INTEG_LIMIT = 200 * 256;

	// Register reset values
	localparam logic [15:0] PROP_GAIN_RST  = 16'd2048;
	localparam logic [15:0] INTEG_GAIN_RST = 16'd26;
	localparam logic [15:0] DERIV_GAIN_RST = 16'd0;

	// Register indexes
	typedef enum logic [1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_DERIV_GAIN = 2'd2
	} cfg_reg_t;

	// Direction pin codes, bit 0 = a, bit 1 = b
	localparam logic [1:0] PINS_NEG = 2'b01;
	localparam logic [1:0] PINS_POS = 2'b10;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
	} gains_t;

	// One classified word between front and back
	typedef struct packed {
		logic [1:0]            channel;
		logic [SLOT_MAX_W-1:0] slot;
		logic [9:0]            err;
		logic [15:0]           sum;
		logic [16:0]           delta;
	} item_t;

	typedef struct packed {
		logic [1:0] channel_out;
		logic [9:0] drive;
		logic [8:0] duty;
		logic       dir_a;
		logic       dir_b;
	} result_t;

	// Channel number folded onto the state entries (channel is below four)
	function automatic logic [SLOT_MAX_W-1:0] chan_fold(input logic [1:0] ch,
			input int unsigned n);
		logic [SLOT_MAX_W-1:0] v;
		v = {{(SLOT_MAX_W-2){1'b0}}, ch};
		for (int k = 0; k < 3; k++) begin
			if (v >= SLOT_MAX_W'(n))
				v = v - SLOT_MAX_W'(n);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/mpid_front.sv */
// Front part: error clamp, integrator and speed-change per channel.
`default_nettype none

module mpid_front import mpid_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  channel,
	input  wire logic [15:0] target_speed,
	input  wire logic [15:0] measured_speed,
	output logic             push,
	output item_t            push_item,
	input  wire logic        full
);

	localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic signed [15:0] error_sum_q [CHANNELS];
	logic signed [15:0] last_speed_q [CHANNELS];

	logic [SLOT_MAX_W-1:0] slot_fold;
	logic [SLOT_W-1:0]  slot;
	logic signed [16:0] diff;
	logic signed [9:0]  err;
	logic signed [16:0] sum_wide;
	logic signed [15:0] sum_new;
	logic signed [16:0] delta;
	logic               accept;

	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign push      = accept;
	assign slot_fold = chan_fold(channel, CHANNELS);
	assign slot      = slot_fold[SLOT_W-1:0];

	// Error clamp, integrator saturation (cleared at zero target speed), speed change
	always_comb begin
		diff = 17'($signed(target_speed)) - 17'($signed(measured_speed));
		if (diff > 17'sd499)
			err = 10'sd499;
		else if (diff < -17'sd499)
			err = -10'sd499;
		else
			err = diff[9:0];
		sum_wide = 17'(error_sum_q[slot]) + 17'(err);
		if (target_speed == 16'd0)
			sum_new = 16'sd0;
		else if (sum_wide > 17'sd32767)
			sum_new = 16'sh7fff;
		else if (sum_wide < -17'sd32768)
			sum_new = 16'sh8000;
		else
			sum_new = sum_wide[15:0];
		delta = 17'($signed(measured_speed)) - 17'(last_speed_q[slot]);
	end

	always_comb begin
		push_item.channel = channel;
		push_item.slot    = SLOT_MAX_W'(slot);
		push_item.err     = err;
		push_item.sum     = sum_new;
		push_item.delta   = delta;
	end

	// Per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				error_sum_q[k]  <= '0;
				last_speed_q[k] <= '0;
			end
		end else if (accept) begin
			error_sum_q[slot]  <= sum_new;
			last_speed_q[slot] <= measured_speed;
		end
	end

endmodule

`default_nettype wire

/* design/mpid_queue.sv */
// Short queue of classified words between front and back.
`default_nettype none

module mpid_queue import mpid_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       not_empty
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* design/mpid_back.sv */
// Back part: gain products, term sum, drive clamp and direction pins.
`default_nettype none

module mpid_back import mpid_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire gains_t gains,
	input  wire logic   item_valid,
	input  wire item_t  item,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output result_t     result
);

	localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Stage 1: products
	logic               valid_s1;
	logic [1:0]         chan_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic signed [26:0] p_s1;
	logic signed [32:0] i_s1;
	logic signed [33:0] d_s1;

	// Stage 2: total
	logic               valid_s2;
	logic [1:0]         chan_s2;
	logic [SLOT_W-1:0]  slot_s2;
	logic signed [35:0] total_s2;

	// Output register
	logic               out_valid_q;
	result_t            result_q;

	logic [1:0]         pins_q [CHANNELS];

	logic               load_out;
	logic               ready_s2;
	logic               ready_s1;
	logic signed [26:0] p_mul;
	logic signed [32:0] i_mul;
	logic signed [33:0] d_mul;
	logic signed [16:0] i_clmp;
	logic signed [35:0] total_c;
	logic               round_up;
	logic signed [27:0] quo;
	logic signed [9:0]  drv;
	logic [1:0]         pins_new;

	// Pipeline flow
	assign load_out  = valid_s2 && (!out_valid_q || out_ready);
	assign ready_s2  = !valid_s2 || !out_valid_q || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pop       = item_valid && ready_s1;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Gain products
	assign p_mul = 27'($signed({1'b0, gains.prop_gain})) * 27'($signed(item.err));
	assign i_mul = 33'($signed({1'b0, gains.integ_gain})) * 33'($signed(item.sum));
	assign d_mul = 34'($signed({1'b0, gains.deriv_gain})) * 34'($signed(item.delta));

	// Integral clamp and term sum
	always_comb begin
		if (i_s1 > 33'sd51200)
			i_clmp = 17'sd51200;
		else if (i_s1 < -33'sd51200)
			i_clmp = -17'sd51200;
		else
			i_clmp = i_s1[16:0];
		total_c = 36'(p_s1) + 36'(i_clmp) + 36'(d_s1);
	end

	// Truncate toward zero, clamp, pins
	always_comb begin
		round_up = total_s2[35] && (total_s2[7:0] != 8'd0);
		quo      = $signed(total_s2[35:8]) + $signed({27'd0, round_up});
		if (quo > 28'sd499)
			drv = 10'sd499;
		else if (quo < -28'sd499)
			drv = -10'sd499;
		else
			drv = quo[9:0];
		if (drv < 10'sd0)
			pins_new = PINS_NEG;
		else if (drv > 10'sd0)
			pins_new = PINS_POS;
		else
			pins_new = pins_q[slot_s2];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < CHANNELS; k++)
				pins_q[k] <= '0;
		end else begin
			if (ready_s1)
				valid_s1 <= item_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (!out_valid_q || out_ready)
				out_valid_q <= valid_s2;
			if (load_out)
				pins_q[slot_s2] <= pins_new;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (pop) begin
			chan_s1 <= item.channel;
			slot_s1 <= item.slot[SLOT_W-1:0];
			p_s1    <= p_mul;
			i_s1    <= i_mul;
			d_s1    <= d_mul;
		end
		if (ready_s2 && valid_s1) begin
			chan_s2  <= chan_s1;
			slot_s2  <= slot_s1;
			total_s2 <= total_c;
		end
		if (load_out) begin
			result_q.channel_out <= chan_s2;
			result_q.drive       <= drv;
			result_q.duty        <= drv[9] ? 9'(-drv) : drv[8:0];
			result_q.dir_a       <= pins_new[0];
			result_q.dir_b       <= pins_new[1];
		end
	end

endmodule

`default_nettype wire

/* design/multichannel_pid_motor_drive.sv */
// Top level of the multichannel PID motor drive.
//
//  port group | role            | word layout, low bit first
//  s_axis_*   | speed samples   | channel[1:0] target_speed[17:2] measured_speed[33:18]
//  m_axis_*   | drive results   | channel_out[1:0] drive[11:2] duty[20:12] dir_a[21] dir_b[22]
//  cfg_*      | gain registers  | 0 prop_gain, 1 integ_gain, 2 deriv_gain
//
// One word per cycle in and out while m_axis is not stalled; a word is written into the queue,
// then registered through the back pipeline (products, term sum, clamp and output register).
// The per-channel integrator and last speed update in the front as a word is
// taken, so words of one channel may follow each other in consecutive cycles.
// Reset clears per-channel state, pins and gains to their defaults; no sweep.
// An output stall backs up the pipeline, then the four-word queue, then s_axis.
`default_nettype none

module multichannel_pid_motor_drive import mpid_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// channel, target_speed, measured_speed, zero pad
	input  wire logic [39:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// channel_out, drive, duty, dir_a, dir_b, zero pad
	output logic [23:0]      m_axis_tdata,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata
);

	gains_t  gains_q;
	logic    push;
	item_t   push_item;
	logic    full;
	logic    pop;
	item_t   pop_item;
	logic    not_empty;
	result_t result;

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain  <= PROP_GAIN_RST;
			gains_q.integ_gain <= INTEG_GAIN_RST;
			gains_q.deriv_gain <= DERIV_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_PROP_GAIN:  gains_q.prop_gain  <= cfg_wdata;
				REG_INTEG_GAIN: gains_q.integ_gain <= cfg_wdata;
				REG_DERIV_GAIN: gains_q.deriv_gain <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mpid_front #(.CHANNELS(CHANNELS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.channel        (s_axis_tdata[1:0]),
		.target_speed   (s_axis_tdata[17:2]),
		.measured_speed (s_axis_tdata[33:18]),
		.push           (push),
		.push_item      (push_item),
		.full           (full)
	);

	mpid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	mpid_back #(.CHANNELS(CHANNELS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains_q),
		.item_valid (not_empty),
		.item       (pop_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.result     (result)
	);

	assign m_axis_tdata = {1'b0, result.dir_b, result.dir_a, result.duty,
		result.drive, result.channel_out};

endmodule

`default_nettype wire

/* design/mpid_port_checker.sv */
// Port-level checks on the drive result stream, bound to the top level.
`default_nettype none
`include "multichannel_pid_motor_drive_macros.svh"

module mpid_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);

	logic signed [9:0] drv;
	logic [9:0]        drv_abs;
	logic [8:0]        duty;
	logic              dir_a;
	logic              dir_b;
	logic              drv_in_range;
	logic              pins_match;
	logic              out_stall;

	assign drv          = m_axis_tdata[11:2];
	assign drv_abs      = drv[9] ? 10'(-drv) : drv;
	assign duty         = m_axis_tdata[20:12];
	assign dir_a        = m_axis_tdata[21];
	assign dir_b        = m_axis_tdata[22];
	assign drv_in_range = (drv <= 10'sd499) && (drv >= -10'sd499);
	assign pins_match   = (dir_a == drv[9]) && (dir_b == !drv[9]);
	assign out_stall    = m_axis_tvalid && !m_axis_tready;

	// Magnitude matches the signed drive
	`MPID_ASSERT_IMP(a_duty_abs, clk, arst_n, m_axis_tvalid, duty == drv_abs[8:0])

	// Drive stays inside the clamp
	`MPID_ASSERT_IMP(a_drive_range, clk, arst_n, m_axis_tvalid, drv_in_range)

	// Nonzero drive sets exactly the matching pin
	`MPID_ASSERT_IMP(a_pins, clk, arst_n, m_axis_tvalid && (drv != 10'sd0), pins_match)

	// A stalled word holds
	`MPID_ASSERT_NXT(a_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind multichannel_pid_motor_drive mpid_port_checker u_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
